// ===== hw/rtl/sha256_pkg.sv =====
// Package: shared types, constants and round functions of the SHA-256 message hash.
package sha256_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned DigestWords = 8;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FINAL = 2'd1,
    KIND_END   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_COMP2,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic put_byte;
    logic put_pad;
    logic start_comp;
    logic round;
    logic finish_comp;
    logic emit_next;
    logic restart;
  } dp_cmd_t;

  typedef struct packed {
    logic       block_full;
    logic       fill_over55;
    logic       rounds_done;
    logic       emit_done;
    logic [2:0] emit_index;
  } dp_stat_t;

  localparam logic [31:0] InitHash [DigestWords] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

// ===== hw/rtl/sha256_ctrl.sv =====
// Controller: sequences byte loads, compressions, padding and digest output.
module sha256_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  logic [1:0]            in_kind,
  input  logic                  out_ready,
  input  sha256_pkg::dp_stat_t  stat,
  output sha256_pkg::dp_cmd_t   cmd,
  output logic                  in_ready,
  output logic                  out_valid
);

  sha256_pkg::state_t state, state_next;
  logic final_pend, final_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha256_pkg::ST_IDLE;
      final_pend <= 1'b0;
    end else begin
      state      <= state_next;
      final_pend <= final_pend_next;
    end
  end

  always_comb begin
    state_next      = state;
    final_pend_next = final_pend;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_kind == sha256_pkg::KIND_END) begin
            state_next      = sha256_pkg::ST_COMP2;
            final_pend_next = 1'b0;
          end else if (in_kind != sha256_pkg::KIND_NONE) begin
            if (stat.block_full) begin
              state_next      = sha256_pkg::ST_COMP;
              final_pend_next = (in_kind == sha256_pkg::KIND_FINAL);
            end else if (in_kind == sha256_pkg::KIND_FINAL) begin
              state_next = sha256_pkg::ST_COMP2;
            end
          end
        end
      end
      sha256_pkg::ST_COMP: begin
        if (stat.rounds_done) begin
          state_next = final_pend ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
        end
      end
      sha256_pkg::ST_PAD: begin
        state_next = sha256_pkg::ST_COMP2;
      end
      sha256_pkg::ST_COMP2: begin
        if (stat.rounds_done) begin
          state_next = stat.fill_over55 ? sha256_pkg::ST_PAD : sha256_pkg::ST_EMIT;
        end
      end
      sha256_pkg::ST_EMIT: begin
        if (out_ready && stat.emit_done) begin
          state_next = sha256_pkg::ST_IDLE;
        end
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_kind == sha256_pkg::KIND_BYTE || in_kind == sha256_pkg::KIND_FINAL) begin
            cmd.put_byte = 1'b1;
          end
          if (in_kind == sha256_pkg::KIND_END ||
              (in_kind == sha256_pkg::KIND_FINAL && !stat.block_full)) begin
            cmd.put_pad = 1'b1;
          end
          if ((in_kind == sha256_pkg::KIND_BYTE || in_kind == sha256_pkg::KIND_FINAL)
              && stat.block_full) begin
            cmd.start_comp = 1'b1;
          end
          if (cmd.put_pad) begin
            cmd.start_comp = 1'b1;
          end
        end
      end
      sha256_pkg::ST_COMP: begin
        cmd.round = 1'b1;
        if (stat.rounds_done) begin
          cmd.finish_comp = 1'b1;
        end
      end
      sha256_pkg::ST_PAD: begin
        cmd.put_pad    = 1'b1;
        cmd.start_comp = 1'b1;
      end
      sha256_pkg::ST_COMP2: begin
        cmd.round = 1'b1;
        if (stat.rounds_done) begin
          cmd.finish_comp = 1'b1;
        end
      end
      sha256_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_next = 1'b1;
          cmd.restart   = stat.emit_done;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/sha256_datapath.sv =====
// Datapath: block buffer, message schedule window, round unit and chaining words.
module sha256_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  sha256_pkg::in_item_t  in_item,
  input  sha256_pkg::dp_cmd_t   cmd,
  output sha256_pkg::dp_stat_t  stat,
  output logic [31:0]           digest_word
);

  logic [31:0] hash  [sha256_pkg::DigestWords];
  logic [31:0] wv    [sha256_pkg::DigestWords];
  logic [31:0] blk   [sha256_pkg::BlockWords];
  logic [6:0]  fill;
  logic [31:0] bit_length;
  logic [5:0]  rnd;
  logic        rnd_last;
  logic        second;
  logic [2:0]  emit_idx;

  logic [5:0]  pos;
  logic [31:0] t1, t2, w_new;
  logic        pad_now;

  // A second padding block is needed when the pad byte left no room for the length.
  assign pad_now = cmd.put_pad;
  assign pos     = fill[5:0];

  always_comb begin
    t1 = wv[7] + sha256_pkg::bsig1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
       + sha256_pkg::RoundK[rnd] + blk[0];
    t2 = sha256_pkg::bsig0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
    w_new = sha256_pkg::sig1(blk[14]) + blk[9] + sha256_pkg::sig0(blk[1]) + blk[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      bit_length <= '0;
      rnd        <= '0;
      rnd_last   <= 1'b0;
      second     <= 1'b0;
      emit_idx   <= '0;
      for (int i = 0; i < sha256_pkg::DigestWords; i++) begin
        hash[i] <= sha256_pkg::InitHash[i];
      end
    end else begin
      if (cmd.put_byte) begin
        for (int i = 0; i < sha256_pkg::BlockWords; i++) begin
          if (pos[5:2] == i[3:0]) begin
            unique case (pos[1:0])
              2'd0: blk[i][31:24] <= in_item.data_byte;
              2'd1: blk[i][23:16] <= in_item.data_byte;
              2'd2: blk[i][15:8]  <= in_item.data_byte;
              default: blk[i][7:0] <= in_item.data_byte;
            endcase
          end
        end
        bit_length <= bit_length + 32'd8;
        fill       <= fill + 7'd1;
      end
      if (pad_now) begin
        // Pad from the current fill; the second block of a long tail is zero but for the length word.
        for (int i = 0; i < sha256_pkg::BlockWords; i++) begin
          for (int b = 0; b < 4; b++) begin
            if (second) begin
              blk[i][31 - 8*b -: 8] <= 8'h00;
            end else if ({i[3:0], b[1:0]} == pos + (cmd.put_byte ? 6'd1 : 6'd0)) begin
              blk[i][31 - 8*b -: 8] <= 8'h80;
            end else if ({i[3:0], b[1:0]} > pos + (cmd.put_byte ? 6'd1 : 6'd0)) begin
              blk[i][31 - 8*b -: 8] <= 8'h00;
            end
          end
        end
        if ((pos + (cmd.put_byte ? 7'd1 : 7'd0)) <= 7'd55 && !second) begin
          blk[14] <= 32'd0;
          blk[15] <= bit_length + (cmd.put_byte ? 32'd8 : 32'd0);
          second  <= 1'b0;
        end else if (second) begin
          blk[14] <= 32'd0;
          blk[15] <= bit_length;
          second  <= 1'b0;
        end else begin
          second <= 1'b1;
        end
      end
      if (cmd.start_comp) begin
        rnd      <= '0;
        rnd_last <= 1'b0;
        for (int i = 0; i < sha256_pkg::DigestWords; i++) begin
          wv[i] <= hash[i];
        end
      end
      if (cmd.round && !rnd_last) begin
        wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
        wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
        for (int i = 0; i < sha256_pkg::BlockWords - 1; i++) begin
          blk[i] <= blk[i + 1];
        end
        blk[15]  <= w_new;
        rnd      <= rnd + 6'd1;
        rnd_last <= (rnd == 6'(sha256_pkg::Rounds - 1));
      end
      if (cmd.finish_comp) begin
        for (int i = 0; i < sha256_pkg::DigestWords; i++) begin
          hash[i] <= hash[i] + wv[i];
        end
        rnd_last <= 1'b0;
        if (fill == 7'd64) begin
          fill <= '0;
        end
      end
      if (cmd.emit_next) begin
        emit_idx <= emit_idx + 3'd1;
      end
      if (cmd.restart) begin
        fill       <= '0;
        bit_length <= '0;
        second     <= 1'b0;
        emit_idx   <= '0;
        for (int i = 0; i < sha256_pkg::DigestWords; i++) begin
          hash[i] <= sha256_pkg::InitHash[i];
        end
      end
    end
  end

  assign stat.block_full  = (fill == 7'd63);
  assign stat.fill_over55 = second;
  assign stat.rounds_done = rnd_last;
  assign stat.emit_done   = (emit_idx == 3'd7);
  assign stat.emit_index  = emit_idx;
  assign digest_word      = hash[emit_idx];

endmodule

// ===== hw/rtl/sha256_message_hash.sv =====
// Top level: SHA-256 message hash fed one byte per item.
//
// Input channel (in, in_valid, in_ready) takes one item: a message byte,
// a final message byte, or an end-of-message mark without a byte. Kind 3
// is dropped. Output channel (out, out_valid, out_ready) gives the eight
// digest words of a message, word 0 first, last_word set on word 7.
//
// A byte that does not complete a 64-byte block is stored and in_ready stays high. A byte
// that completes a block starts the compression: 64 rounds, one a cycle,
// then the fold into the chaining words; throughout, in_ready
// is low. End of message pads and compresses one block, or two when more
// than 55 bytes stand in the last block, then holds the eight words until
// the receiver takes them; a stalled receiver holds the block in output.
// The words leave at one per cycle while the receiver holds out_ready high.
// After the last word the initial hash is restored for the next message.
// Reset loads the initial hash and clears the length and fill count.
module sha256_message_hash (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256_pkg::in_item_t   in,
  input  logic                   in_valid,
  output logic                   in_ready,
  output sha256_pkg::out_item_t  out,
  output logic                   out_valid,
  input  logic                   out_ready
);

  sha256_pkg::dp_cmd_t  cmd;
  sha256_pkg::dp_stat_t stat;
  logic [31:0] digest_word;

  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_valid && in_ready),
    .in_kind   (in.kind),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  sha256_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_item     (in),
    .cmd         (cmd),
    .stat        (stat),
    .digest_word (digest_word)
  );

  assign out.digest_word = digest_word;
  assign out.word_index  = stat.emit_index;
  assign out.last_word   = stat.emit_done;

endmodule
